// ----- hdl/timestamp_kway_merge_macros.svh -----
// assertion macros for the timestamp merge block
// used by the top level, relies on clk and rst_n in the including module
`ifndef TIMESTAMP_KWAY_MERGE_MACROS_SVH
`define TIMESTAMP_KWAY_MERGE_MACROS_SVH

// same-cycle implication
`define TKM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/tkm_pkg.sv -----
// shared constants and codes for the timestamp merge block
// no dependencies
package tkm_pkg;
  localparam int MAX_SOURCES_DEF = 16;
  localparam int TS_W = 64;
  localparam int SRC_FIELD_W = 4;
  localparam int ACTIVE_W = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

  localparam logic [1:0] REQ_OFFER = 2'd0;
  localparam logic [1:0] REQ_EXHAUST = 2'd1;
  localparam logic [1:0] REQ_TAKE = 2'd2;

  localparam logic [1:0] PH_AWAIT = 2'd0;
  localparam logic [1:0] PH_HOLD = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_DELIVERED = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_WAITING = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;

  localparam int CFG_AW = 3;
  localparam logic [CFG_AW-1:0] ADDR_ACTIVE = 3'd0;
endpackage

// ----- hdl/tkm_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module tkm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hdl/tkm_cfg.sv -----
// apb-style register for the active source count, with clamped count output
// depends on tkm_pkg
module tkm_cfg #(
  parameter int MAX_SOURCES = 16,
  parameter int CW = 9
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tkm_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [CW-1:0]              count
);
  import tkm_pkg::*;

  logic [ACTIVE_W-1:0] active_r, active_nxt;
  logic [CW-1:0] act_ext;

  always_comb begin
    active_nxt = active_r;
    if (psel && penable && pwrite && paddr == ADDR_ACTIVE) begin
      active_nxt = pwdata[ACTIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RST;
    end else begin
      active_r <= active_nxt;
    end
  end

  // zero acts as one, above the source count acts as the source count
  always_comb begin
    act_ext = CW'(active_r);
    if (act_ext == '0) begin
      count = CW'(1);
    end else if (act_ext > CW'(MAX_SOURCES)) begin
      count = CW'(MAX_SOURCES);
    end else begin
      count = act_ext;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ACTIVE) ? 32'(active_r) : 32'd0;
endmodule

// ----- hdl/timestamp_kway_merge.sv -----
// timestamp k-way merge
// in_ channel carries requests: in_tuser is the request kind, in_tdata holds
// source and timestamp. out_ channel carries one result item per request.
// offer and exhausted requests update the phase of one source, and an offer
// writes the head timestamp memory; they do not enter the scan, and the result
// item shows on out_ the cycle after acceptance.
// a take request walks the head memory one source per cycle, reading the
// timestamp of every holding source and keeping the smallest (lowest index
// wins a tie); the winner goes to the result register when the scan ends.
// waiting and all-exhausted outcomes of a take are decided at acceptance, without a scan.
// one request is in progress at a time; a new item is accepted as soon as the
// engine is idle and the result register is empty or being drained.
// a stalled receiver holds the result register and with it in_tready.
// reset marks every source awaiting a head and sets active_sources to 16;
// the head memory is not cleared.
// depends on tkm_pkg, tkm_ram, tkm_cfg, timestamp_kway_merge_macros.svh
module timestamp_kway_merge #(
  parameter int MAX_SOURCES = tkm_pkg::MAX_SOURCES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [71:0]                in_tdata,  // source[3:0], timestamp[67:4], zero pad
  input  logic [1:0]                 in_tuser,  // req_type[1:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [71:0]                out_tdata, // winner_source[3:0], winner_timestamp[67:4]
  output logic [2:0]                 out_tuser, // status[2:0]
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [tkm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import tkm_pkg::*;
  `include "timestamp_kway_merge_macros.svh"

  localparam int SRC_W = $clog2(MAX_SOURCES);
  localparam int CNT_W = $clog2(MAX_SOURCES + 1);
  localparam int CW = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic [CW-1:0] n_eff;

  tkm_cfg #(.MAX_SOURCES(MAX_SOURCES), .CW(CW)) u_cfg (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .pready(cfg_pready), .count(n_eff)
  );

  logic [1:0] phase_r [MAX_SOURCES];
  logic [1:0] phase_nxt [MAX_SOURCES];
  logic state_r, state_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic pv_r, pv_nxt;
  logic [SRC_W-1:0] pidx_r, pidx_nxt;
  logic bfound_r, bfound_nxt;
  logic [SRC_W-1:0] bidx_r, bidx_nxt;
  logic [TS_W-1:0] bts_r, bts_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] out_status_r, out_status_nxt;
  logic [SRC_FIELD_W-1:0] out_src_r, out_src_nxt;
  logic [TS_W-1:0] out_ts_r, out_ts_nxt;

  logic [1:0] req;
  logic [SRC_FIELD_W-1:0] src_in;
  logic [TS_W-1:0] ts_in;
  logic [CW-1:0] src_ext;
  logic [SRC_W-1:0] src_idx;
  logic accept;
  logic owing, any_hold;
  logic mem_we;
  logic [TS_W-1:0] rd_data;

  assign req = in_tuser;
  assign src_in = in_tdata[3:0];
  assign ts_in = in_tdata[67:4];
  assign src_ext = CW'(src_in);
  assign src_idx = src_ext[SRC_W-1:0];
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept = in_tvalid && in_tready;
  assign mem_we = accept && req == REQ_OFFER && src_ext < n_eff &&
                  phase_r[src_idx] == PH_AWAIT;

  tkm_ram #(.WIDTH(TS_W), .DEPTH(MAX_SOURCES)) u_head (
    .clk(clk), .we(mem_we), .waddr(src_idx), .wdata(ts_in),
    .raddr(idx_r[SRC_W-1:0]), .rdata(rd_data)
  );

  always_comb begin
    owing = 1'b0;
    any_hold = 1'b0;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if (CW'(i) < n_eff) begin
        if (phase_r[i] == PH_AWAIT) owing = 1'b1;
        if (phase_r[i] == PH_HOLD) any_hold = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    pv_nxt = 1'b0;
    pidx_nxt = pidx_r;
    bfound_nxt = bfound_r;
    bidx_nxt = bidx_r;
    bts_nxt = bts_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_src_nxt = out_src_r;
    out_ts_nxt = out_ts_r;
    for (int i = 0; i < MAX_SOURCES; i++) phase_nxt[i] = phase_r[i];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_status_nxt = ST_REJECTED;
          out_src_nxt = '0;
          out_ts_nxt = '0;
          if (req == REQ_OFFER || req == REQ_EXHAUST) begin
            if (src_ext < n_eff && phase_r[src_idx] == PH_AWAIT) begin
              phase_nxt[src_idx] = (req == REQ_OFFER) ? PH_HOLD : PH_DONE;
              out_status_nxt = ST_ACCEPTED;
            end
          end else if (req == REQ_TAKE) begin
            if (owing) begin
              out_status_nxt = ST_WAITING;
            end else if (!any_hold) begin
              out_status_nxt = ST_EXHAUSTED;
            end else begin
              // result comes out of the scan
              out_valid_nxt = 1'b0;
              state_nxt = S_SCAN;
              idx_nxt = '0;
              bfound_nxt = 1'b0;
            end
          end
        end
      end
      S_SCAN: begin
        if (idx_r < n_eff) begin
          pv_nxt = phase_r[idx_r[SRC_W-1:0]] == PH_HOLD;
          pidx_nxt = idx_r[SRC_W-1:0];
          idx_nxt = idx_r + CW'(1);
        end
        if (pv_r && (!bfound_r || rd_data < bts_r)) begin
          bfound_nxt = 1'b1;
          bidx_nxt = pidx_r;
          bts_nxt = rd_data;
        end
        if (idx_r >= n_eff && !pv_r) begin
          state_nxt = S_IDLE;
          phase_nxt[bidx_r] = PH_AWAIT;
          out_valid_nxt = 1'b1;
          out_status_nxt = ST_DELIVERED;
          out_src_nxt = SRC_FIELD_W'(CW'(bidx_r));
          out_ts_nxt = bts_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pv_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_SOURCES; i++) phase_r[i] <= PH_AWAIT;
    end else begin
      state_r <= state_nxt;
      pv_r <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < MAX_SOURCES; i++) phase_r[i] <= phase_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pidx_r <= pidx_nxt;
    bfound_r <= bfound_nxt;
    bidx_r <= bidx_nxt;
    bts_r <= bts_nxt;
    out_status_r <= out_status_nxt;
    out_src_r <= out_src_nxt;
    out_ts_r <= out_ts_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser = out_status_r;
  assign out_tdata = {4'd0, out_ts_r, out_src_r};

  `TKM_ASSERT_NOW(a_ready_idle, in_tready, state_r == S_IDLE && !pv_r,
    "input ready while a take is in progress")
  `TKM_ASSERT_NOW(a_zero_fields, out_valid_r && out_status_r != ST_DELIVERED,
    out_src_r == '0 && out_ts_r == '0, "winner fields not zero")
  `TKM_ASSERT_NEXT(a_scan_no_out, state_r == S_SCAN && state_nxt == S_SCAN,
    !out_valid_r, "result present during a scan")
endmodule
